// ----- rtl/ookd_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ookd_pkg
// Shared types and constants of the on-off-keyed pulse frame decoder.
// ----------------------------------------------------------------------------
package ookd_pkg;

   localparam int unsigned DUR_W      = 16;
   localparam int unsigned UNIT_W     = 11;
   localparam int unsigned COUNT_W    = 6;
   localparam int unsigned CODE_W     = 24;
   localparam int unsigned CODE_IDX_W = 5;
   localparam int unsigned CSR_ADDR_W = 4;
   localparam int unsigned CSR_DATA_W = 32;

   localparam logic [COUNT_W-1:0] FRAME_LEN = 6'd49;
   localparam logic [COUNT_W-1:0] COUNT_MAX = 6'd63;

   localparam logic [UNIT_W-1:0] SYNC_LOW_RESET  = 11'd300;
   localparam logic [UNIT_W-1:0] SYNC_HIGH_RESET = 11'd400;
   localparam logic [DUR_W-1:0]  LIMIT_RESET     = 16'd700;

   // register indexes, taken from paddr[3:2]
   localparam logic [1:0] REG_SYNC_LOW  = 2'd0;
   localparam logic [1:0] REG_SYNC_HIGH = 2'd1;
   localparam logic [1:0] REG_LIMIT     = 2'd2;

   typedef enum logic [2:0] {
      ST_OK     = 3'd0,
      ST_LENGTH = 3'd1,
      ST_SYNC   = 3'd2,
      ST_PAIR   = 3'd3,
      ST_NIBBLE = 3'd4,
      ST_FAMILY = 3'd5,
      ST_BUTTON = 3'd6,
      ST_POWER  = 3'd7
   } status_type;

   typedef struct packed {
      logic sync_ok;
      logic first_long;
      logic second_long;
   } pulse_class_type;

   typedef struct packed {
      status_type  status;
      logic [3:0]  family_index;
      logic [4:0]  button_number;
      logic        power_on;
   } frame_result_type;

endpackage : ookd_pkg
`default_nettype wire

// ----- rtl/ookd_pulse_classify.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ookd_pulse_classify
// Sync window test and short/long classification of one pulse duration.
// ----------------------------------------------------------------------------
module ookd_pulse_classify (
   input  wire logic [ookd_pkg::DUR_W-1:0]  duration,
   input  wire logic [ookd_pkg::UNIT_W-1:0] sync_unit_low,
   input  wire logic [ookd_pkg::UNIT_W-1:0] sync_unit_high,
   input  wire logic [ookd_pkg::DUR_W-1:0]  short_long_limit,
   output ookd_pkg::pulse_class_type        pulse_class
);
   import ookd_pkg::*;

   localparam int unsigned BOUND_W = UNIT_W + 6;

   logic [UNIT_W:0]    low_plus_one;
   logic [BOUND_W-1:0] low_bound;
   logic [BOUND_W-1:0] high_bound;
   logic [BOUND_W-1:0] dur_ext;

   // floor(d/31) > lo  <=>  d >= 31*(lo+1);  floor(d/31) < hi  <=>  d < 31*hi
   assign low_plus_one = {1'b0, sync_unit_low} + {{UNIT_W{1'b0}}, 1'b1};
   assign low_bound    = ({{(BOUND_W-UNIT_W-1){1'b0}}, low_plus_one} << 5)
                       - {{(BOUND_W-UNIT_W-1){1'b0}}, low_plus_one};
   assign high_bound   = ({{(BOUND_W-UNIT_W){1'b0}}, sync_unit_high} << 5)
                       - {{(BOUND_W-UNIT_W){1'b0}}, sync_unit_high};
   assign dur_ext      = {{(BOUND_W-DUR_W){1'b0}}, duration};

   assign pulse_class.sync_ok     = (dur_ext >= low_bound) && (dur_ext < high_bound);
   assign pulse_class.first_long  = duration > short_long_limit;
   assign pulse_class.second_long = duration >= short_long_limit;

endmodule : ookd_pulse_classify
`default_nettype wire

// ----- rtl/ookd_code_check.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ookd_code_check
// Frame status and field decode from the accumulated frame state.
// ----------------------------------------------------------------------------
module ookd_code_check (
   input  wire logic [ookd_pkg::COUNT_W-1:0] pulse_count,
   input  wire logic                         sync_good,
   input  wire logic                         pair_error,
   input  wire logic [ookd_pkg::CODE_W-1:0]  code_bits,
   output ookd_pkg::frame_result_type        result
);
   import ookd_pkg::*;

   logic       nibble_ok;
   logic       family_ok;
   logic       button_ok;
   logic       power_ok;
   logic [3:0] family_val;
   logic [3:0] button_val;

   assign nibble_ok  = code_bits[19:16] == 4'b1000;
   assign family_ok  = !(code_bits[0] | code_bits[2] | code_bits[4] | code_bits[6]);
   assign button_ok  = !(code_bits[8] | code_bits[10] | code_bits[12] | code_bits[14]);
   assign power_ok   = !code_bits[20] && code_bits[21] && !code_bits[22];
   assign family_val = {code_bits[7], code_bits[5], code_bits[3], code_bits[1]};
   assign button_val = {code_bits[15], code_bits[13], code_bits[11], code_bits[9]};

   always_comb begin
      result.status        = ST_OK;
      result.family_index  = family_val;
      result.button_number = {1'b0, button_val} + 5'd1;
      result.power_on      = code_bits[23];
      // first failing check wins
      if (pulse_count != FRAME_LEN) begin
         result.status = ST_LENGTH;
      end else if (!sync_good) begin
         result.status = ST_SYNC;
      end else if (pair_error) begin
         result.status = ST_PAIR;
      end else if (!nibble_ok) begin
         result.status = ST_NIBBLE;
      end else if (!family_ok) begin
         result.status = ST_FAMILY;
      end else if (!button_ok) begin
         result.status = ST_BUTTON;
      end else if (!power_ok) begin
         result.status = ST_POWER;
      end
      if (result.status != ST_OK) begin
         result.family_index  = '0;
         result.button_number = '0;
         result.power_on      = 1'b0;
      end
   end

endmodule : ookd_code_check
`default_nettype wire

// ----- rtl/ook_pulse_frame_decoder.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ook_pulse_frame_decoder
// Decodes 49-pulse on-off-keyed remote frames into family, button and power.
// ----------------------------------------------------------------------------
//   channel  direction  handshake          payload
//   req      in         req_valid/stall    pulse_duration, frame_end
//   rsp      out        rsp_valid/stall    status, family_index, button_number,
//                                          power_on
//   csr      in/out     APB psel/penable   sync_unit_low/high, short_long_limit
//
// One pulse per cycle while the input is not stalled. A pulse is registered at
// the input, then classified and folded into the frame state in the next
// cycle; a frame-end pulse loads the result register with the frame status.
// Reset is synchronous; it clears frame state and valids and loads the register defaults.
// A stalled result holds only a following frame-end pulse in the input register;
// the input stalls behind it, while the earlier pulses keep flowing.
// ----------------------------------------------------------------------------
module ook_pulse_frame_decoder (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // pulse input
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic [ookd_pkg::DUR_W-1:0]      req_pulse_duration,
   input  wire logic                            req_frame_end,
   // frame result
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic [2:0]                           rsp_status,
   output logic [3:0]                           rsp_family_index,
   output logic [4:0]                           rsp_button_number,
   output logic                                 rsp_power_on,
   // register port
   input  wire logic                            psel,
   input  wire logic                            penable,
   input  wire logic                            pwrite,
   input  wire logic [ookd_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic [ookd_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [ookd_pkg::CSR_DATA_W-1:0]      prdata,
   output logic                                 pready
);
   import ookd_pkg::*;

   logic [UNIT_W-1:0] sync_low_ff;
   logic [UNIT_W-1:0] sync_high_ff;
   logic [DUR_W-1:0]  limit_ff;
   logic              csr_write;
   logic [1:0]        csr_index;

   logic              in_valid_ff;
   logic              in_valid_in;
   logic [DUR_W-1:0]  in_dur_ff;
   logic              in_last_ff;
   logic              in_blocked;
   logic              process;

   logic [COUNT_W-1:0]    count_ff,      count_in;
   logic                  sync_good_ff,  sync_good_in;
   logic                  first_long_ff, first_long_in;
   logic                  pair_err_ff,   pair_err_in;
   logic [CODE_W-1:0]     code_ff,       code_in;
   logic [COUNT_W-1:0]    count_next;
   logic                  sync_good_next;
   logic                  first_long_next;
   logic                  pair_err_next;
   logic [CODE_W-1:0]     code_next;
   logic [CODE_IDX_W-1:0] bit_idx;

   logic              rsp_valid_ff, rsp_valid_in;
   frame_result_type  rsp_ff;
   frame_result_type  frame_result;
   pulse_class_type   pulse_class;

   // ---- register port ----
   assign pready    = 1'b1;
   assign csr_index = paddr[3:2];
   assign csr_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_low_ff  <= SYNC_LOW_RESET;
         sync_high_ff <= SYNC_HIGH_RESET;
         limit_ff     <= LIMIT_RESET;
      end else if (csr_write) begin
         case (csr_index)
            REG_SYNC_LOW:  sync_low_ff  <= pwdata[UNIT_W-1:0];
            REG_SYNC_HIGH: sync_high_ff <= pwdata[UNIT_W-1:0];
            REG_LIMIT:     limit_ff     <= pwdata[DUR_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_SYNC_LOW:  prdata = {{(CSR_DATA_W-UNIT_W){1'b0}}, sync_low_ff};
         REG_SYNC_HIGH: prdata = {{(CSR_DATA_W-UNIT_W){1'b0}}, sync_high_ff};
         REG_LIMIT:     prdata = {{(CSR_DATA_W-DUR_W){1'b0}}, limit_ff};
         default:       prdata = '0;
      endcase
   end

   // ---- input register ----
   // a frame-end pulse waits while the previous result is still stalled
   assign in_blocked  = in_valid_ff && in_last_ff && rsp_valid_ff && rsp_stall;
   assign req_stall   = in_blocked;
   assign process     = in_valid_ff && !in_blocked;
   assign in_valid_in = in_blocked ? in_valid_ff : req_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!in_blocked) begin
         in_dur_ff  <= req_pulse_duration;
         in_last_ff <= req_frame_end;
      end
   end

   // ---- frame state ----
   ookd_pulse_classify u_classify (
      .duration         (in_dur_ff),
      .sync_unit_low    (sync_low_ff),
      .sync_unit_high   (sync_high_ff),
      .short_long_limit (limit_ff),
      .pulse_class      (pulse_class)
   );

   assign bit_idx = count_ff[COUNT_W-1:1] - 5'd1;

   always_comb begin
      sync_good_next  = sync_good_ff;
      first_long_next = first_long_ff;
      pair_err_next   = pair_err_ff;
      code_next       = code_ff;
      if (count_ff == '0) begin
         sync_good_next = pulse_class.sync_ok;
      end else if (count_ff < FRAME_LEN) begin
         if (count_ff[0]) begin
            first_long_next = pulse_class.first_long;
         end else if (!first_long_ff && pulse_class.second_long) begin
            code_next[bit_idx] = 1'b0;
         end else if (first_long_ff && !pulse_class.second_long) begin
            code_next[bit_idx] = 1'b1;
         end else begin
            pair_err_next = 1'b1;
         end
      end
      count_next = (count_ff < COUNT_MAX) ? count_ff + 6'd1 : count_ff;
   end

   ookd_code_check u_check (
      .pulse_count (count_next),
      .sync_good   (sync_good_next),
      .pair_error  (pair_err_next),
      .code_bits   (code_next),
      .result      (frame_result)
   );

   always_comb begin
      count_in      = count_ff;
      sync_good_in  = sync_good_ff;
      first_long_in = first_long_ff;
      pair_err_in   = pair_err_ff;
      code_in       = code_ff;
      if (process) begin
         if (in_last_ff) begin
            count_in      = '0;
            sync_good_in  = 1'b0;
            first_long_in = 1'b0;
            pair_err_in   = 1'b0;
            code_in       = '0;
         end else begin
            count_in      = count_next;
            sync_good_in  = sync_good_next;
            first_long_in = first_long_next;
            pair_err_in   = pair_err_next;
            code_in       = code_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         sync_good_ff  <= 1'b0;
         first_long_ff <= 1'b0;
         pair_err_ff   <= 1'b0;
         code_ff       <= '0;
      end else begin
         count_ff      <= count_in;
         sync_good_ff  <= sync_good_in;
         first_long_ff <= first_long_in;
         pair_err_ff   <= pair_err_in;
         code_ff       <= code_in;
      end
   end

   // ---- result register ----
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (process && in_last_ff) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (process && in_last_ff) begin
         rsp_ff <= frame_result;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_ff.status;
   assign rsp_family_index  = rsp_ff.family_index;
   assign rsp_button_number = rsp_ff.button_number;
   assign rsp_power_on      = rsp_ff.power_on;

endmodule : ook_pulse_frame_decoder
`default_nettype wire

// ----- dv/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// OOK pulse frame decoder testbench
// Feeds pulse-duration frames (well-formed codes, single-fault frames, wrong
// lengths and noise) under random sender bursts and receiver stalls, predicts
// each frame status in a scoreboard class and checks every result transfer.
// Register settings change between phases, extremes included.
// ----------------------------------------------------------------------------
module testbench;
   import ookd_pkg::*;

   localparam int unsigned ITEM_TARGET      = 1050;
   localparam int unsigned FRAMES_PER_PHASE = 6;
   localparam int unsigned DRAIN_CYCLES     = 6;
   localparam int unsigned IDLE_LIMIT       = 5000;
   localparam int unsigned UNIT_MAX         = 65535 / 31;
   localparam logic [1:0]  REG_UNUSED       = 2'd3;

   typedef enum int unsigned {
      FR_GOOD, FR_RANDOM_CODE, FR_BAD_SYNC, FR_BAD_PAIR, FR_BAD_NIBBLE,
      FR_BAD_FAMILY, FR_BAD_BUTTON, FR_BAD_POWER, FR_SHORT, FR_LONG, FR_NOISE
   } frame_kind_type;

   // frame decode predictor and queue of expected frame statuses
   class frame_scoreboard;
      logic [UNIT_W-1:0]  unit_low;
      logic [UNIT_W-1:0]  unit_high;
      logic [DUR_W-1:0]   limit;
      logic [COUNT_W-1:0] count;
      logic               sync_ok;
      logic               first_long;
      logic               pair_bad;
      logic [CODE_W-1:0]  code;
      frame_result_type   pending_frames[$];
      int unsigned        errors;
      int unsigned        results;

      function new();
         unit_low  = SYNC_LOW_RESET;
         unit_high = SYNC_HIGH_RESET;
         limit     = LIMIT_RESET;
         errors    = 0;
         results   = 0;
         clear_frame();
      endfunction

      function void clear_frame();
         count      = '0;
         sync_ok    = 1'b0;
         first_long = 1'b0;
         pair_bad   = 1'b0;
         code       = '0;
      endfunction

      function void set_reg(logic [1:0] idx, logic [31:0] value);
         case (idx)
            REG_SYNC_LOW:  unit_low  = value[UNIT_W-1:0];
            REG_SYNC_HIGH: unit_high = value[UNIT_W-1:0];
            REG_LIMIT:     limit     = value[DUR_W-1:0];
            default: ;
         endcase
      endfunction

      function logic [31:0] reg_value(logic [1:0] idx);
         case (idx)
            REG_SYNC_LOW:  return 32'(unit_low);
            REG_SYNC_HIGH: return 32'(unit_high);
            REG_LIMIT:     return 32'(limit);
            default:       return '0;
         endcase
      endfunction

      // even bits of the byte must be clear, odd bits carry weights 1,2,4,8
      function bit byte_field(int unsigned base, output logic [3:0] v);
         v = '0;
         for (int j = 0; j < 4; j++) begin
            if (code[base + 2*j]) return 1'b0;
            v[j] = code[base + 2*j + 1];
         end
         return 1'b1;
      endfunction

      function frame_result_type judge_frame();
         frame_result_type r;
         logic [3:0]       fam;
         logic [3:0]       btn;
         bit               fam_ok;
         bit               btn_ok;
         r      = '0;
         fam_ok = byte_field(0, fam);
         btn_ok = byte_field(8, btn);
         if (count != FRAME_LEN) r.status = ST_LENGTH;
         else if (!sync_ok) r.status = ST_SYNC;
         else if (pair_bad) r.status = ST_PAIR;
         else if (code[19:16] != 4'b1000) r.status = ST_NIBBLE;
         else if (!fam_ok) r.status = ST_FAMILY;
         else if (!btn_ok) r.status = ST_BUTTON;
         else if (code[22:20] != 3'b010) r.status = ST_POWER;
         else begin
            r.status        = ST_OK;
            r.family_index  = fam;
            r.button_number = {1'b0, btn} + 5'd1;
            r.power_on      = code[23];
         end
         return r;
      endfunction

      function void note_pulse(logic [DUR_W-1:0] dur, logic last);
         int unsigned unit;
         int unsigned k;
         logic        second_long;
         unit = dur / 31;
         if (count == 0) begin
            sync_ok = (unit > unit_low) && (unit < unit_high);
         end else if (count < FRAME_LEN) begin
            // first pulse of a pair is short at the limit, second is long there
            if (count[0]) begin
               first_long = dur > limit;
            end else begin
               second_long = dur >= limit;
               k = count / 2 - 1;
               if (first_long && !second_long) code[k] = 1'b1;
               else if (first_long || !second_long) pair_bad = 1'b1;
            end
         end
         if (count != COUNT_MAX) count++;
         if (last) begin
            pending_frames.push_back(judge_frame());
            clear_frame();
         end
      endfunction

      function void check_status(frame_result_type got);
         frame_result_type want;
         results++;
         if (pending_frames.size() == 0) begin
            $display("%0t: unexpected result, status %0d", $time, got.status);
            errors++;
            return;
         end
         want = pending_frames.pop_front();
         if (got.status != want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
            errors++;
         end
         if (got.family_index != want.family_index) begin
            $display("%0t: family_index expected %0d actual %0d", $time,
                     want.family_index, got.family_index);
            errors++;
         end
         if (got.button_number != want.button_number) begin
            $display("%0t: button_number expected %0d actual %0d", $time,
                     want.button_number, got.button_number);
            errors++;
         end
         if (got.power_on != want.power_on) begin
            $display("%0t: power_on expected %0d actual %0d", $time,
                     want.power_on, got.power_on);
            errors++;
         end
      endfunction

      function int unsigned waiting();
         return pending_frames.size();
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [DUR_W-1:0]      req_pulse_duration = '0;
   logic                  req_frame_end = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [2:0]            rsp_status;
   logic [3:0]            rsp_family_index;
   logic [4:0]            rsp_button_number;
   logic                  rsp_power_on;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   frame_scoreboard  sb = new();
   logic [DUR_W-1:0] frame_pulses[$];
   int unsigned      items_sent = 0;
   int unsigned      burst_left = 0;
   int unsigned      idle_cycles = 0;
   int unsigned      stall_mode = 0;
   int unsigned      stall_left = 0;

   ook_pulse_frame_decoder dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_pulse_duration(req_pulse_duration),
      .req_frame_end     (req_frame_end),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_family_index  (rsp_family_index),
      .rsp_button_number (rsp_button_number),
      .rsp_power_on      (rsp_power_on),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   always #10 clock = ~clock;

   // receiver: runs of no stall, light, half and heavy stall
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_left = $urandom_range(16, 160);
      end
      stall_left--;
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= 1'($urandom_range(0, 1));
         2: rsp_stall <= ($urandom_range(0, 7) == 0);
         default: rsp_stall <= ($urandom_range(0, 9) != 0);
      endcase
   end

   // outputs sampled mid-cycle, ahead of the edge that completes the transfer
   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall)
            sb.check_status(frame_result_type'({rsp_status, rsp_family_index,
                                                rsp_button_number, rsp_power_on}));
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (psel && penable))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("ook_pulse_frame_decoder test failed");
            $finish;
         end
      end
   end

   // value in [lo, hi], leaning on the ends
   function automatic logic [DUR_W-1:0] pick(int unsigned lo, int unsigned hi);
      case ($urandom_range(0, 7))
         0: return DUR_W'(lo);
         1: return DUR_W'(hi);
         default: return DUR_W'($urandom_range(hi, lo));
      endcase
   endfunction

   function automatic logic [DUR_W-1:0] pair_pulse(bit second, bit want_long);
      int unsigned lim;
      lim = 32'(sb.limit);
      if (!second) begin
         if (!want_long) return pick(0, lim);
         if (lim == 65535) return '1;
         return pick(lim + 1, 65535);
      end
      if (want_long) return pick(lim, 65535);
      if (lim == 0) return '0;
      return pick(0, lim - 1);
   endfunction

   function automatic logic [DUR_W-1:0] sync_pulse(bit good);
      int unsigned lo;
      int unsigned hi;
      int unsigned unit;
      int unsigned d;
      if (good) begin
         lo = sb.unit_low + 1;
         hi = (sb.unit_high == 0) ? 0 : sb.unit_high - 1;
         if (hi > UNIT_MAX) hi = UNIT_MAX;
         if (lo > hi) return DUR_W'($urandom);
         unit = 32'(pick(lo, hi));
      end else if (sb.unit_high <= UNIT_MAX && $urandom_range(0, 1)) begin
         unit = 32'(pick(sb.unit_high, UNIT_MAX));
      end else begin
         unit = 32'(pick(0, sb.unit_low));
      end
      d = unit * 31 + $urandom_range(0, 30);
      return (d > 65535) ? '1 : DUR_W'(d);
   endfunction

   function automatic logic [CODE_W-1:0] valid_code();
      logic [CODE_W-1:0] c;
      logic [3:0]        fam;
      logic [3:0]        btn;
      fam = 4'($urandom);
      btn = 4'($urandom);
      c   = '0;
      for (int j = 0; j < 4; j++) begin
         c[2*j + 1]     = fam[j];
         c[8 + 2*j + 1] = btn[j];
      end
      c[19] = 1'b1;
      c[21] = 1'b1;
      c[23] = 1'($urandom_range(0, 1));
      return c;
   endfunction

   function automatic void build_frame(frame_kind_type kind);
      logic [CODE_W-1:0] c;
      int                broken;
      bit                both_long;
      int unsigned       n;
      c      = valid_code();
      broken = -1;
      case (kind)
         FR_RANDOM_CODE: c = CODE_W'($urandom);
         FR_BAD_PAIR:    broken = $urandom_range(0, 23);
         FR_BAD_NIBBLE:  c[$urandom_range(16, 19)] ^= 1'b1;
         FR_BAD_FAMILY:  c[2 * $urandom_range(0, 3)] = 1'b1;
         FR_BAD_BUTTON:  c[8 + 2 * $urandom_range(0, 3)] = 1'b1;
         FR_BAD_POWER: begin
            do c[22:20] = 3'($urandom); while (c[22:20] == 3'b010);
         end
         default: ;
      endcase
      frame_pulses.delete();
      frame_pulses.push_back(sync_pulse(kind != FR_BAD_SYNC));
      for (int k = 0; k < 24; k++) begin
         if (k == broken) begin
            both_long = 1'($urandom_range(0, 1));
            frame_pulses.push_back(pair_pulse(0, both_long));
            frame_pulses.push_back(pair_pulse(1, both_long));
         end else begin
            frame_pulses.push_back(pair_pulse(0, c[k]));
            frame_pulses.push_back(pair_pulse(1, !c[k]));
         end
      end
      if (kind == FR_SHORT) begin
         n = $urandom_range(1, 48);
         while (frame_pulses.size() > n) void'(frame_pulses.pop_back());
      end else if (kind == FR_LONG) begin
         // past 63 the count must hold; 113 would alias to 49 if it wrapped
         case ($urandom_range(0, 5))
            0: n = 50;
            1: n = 63;
            2: n = 64;
            3: n = 113;
            default: n = $urandom_range(50, 127);
         endcase
         while (frame_pulses.size() < n) frame_pulses.push_back(DUR_W'($urandom));
      end else if (kind == FR_NOISE) begin
         n = $urandom_range(1, 60);
         frame_pulses.delete();
         repeat (n) frame_pulses.push_back(DUR_W'($urandom));
      end
   endfunction

   function automatic frame_kind_type pick_kind(int unsigned frame_no);
      int unsigned r;
      if (frame_no <= FR_NOISE) return frame_kind_type'(frame_no);
      r = $urandom_range(0, 99);
      if (r < 45) return FR_GOOD;
      if (r < 55) return FR_RANDOM_CODE;
      if (r < 75) return frame_kind_type'($urandom_range(FR_BAD_SYNC, FR_BAD_POWER));
      if (r < 93) return FR_SHORT;
      if (r < 97) return FR_LONG;
      return FR_NOISE;
   endfunction

   task automatic send_pulse(logic [DUR_W-1:0] dur, logic last);
      bit took;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 30);
         if ($urandom_range(0, 3) != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
      burst_left--;
      req_valid          <= 1'b1;
      req_pulse_duration <= dur;
      req_frame_end      <= last;
      do begin
         @(negedge clock);
         took = !req_stall;
         @(posedge clock);
      end while (!took);
      sb.note_pulse(dur, last);
      items_sent++;
   endtask

   task automatic send_frame();
      foreach (frame_pulses[i]) send_pulse(frame_pulses[i], i == frame_pulses.size() - 1);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (sb.waiting() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_access(logic wr, logic [1:0] idx, logic [31:0] wdata,
                             output logic [31:0] rdata);
      bit done;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= {idx, 2'b00};
      pwdata  <= wdata;
      @(posedge clock);
      penable <= 1'b1;
      do begin
         @(negedge clock);
         done  = pready;
         rdata = prdata;
         @(posedge clock);
      end while (!done);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [31:0] value);
      logic [31:0] rd;
      csr_access(1'b1, idx, value, rd);
      sb.set_reg(idx, value);
      if (idx != REG_UNUSED) begin
         csr_access(1'b0, idx, $urandom, rd);
         if (rd !== sb.reg_value(idx)) begin
            $display("%0t: register %0d readback expected %0h actual %0h", $time, idx,
                     sb.reg_value(idx), rd);
            sb.errors++;
         end
      end
   endtask

   task automatic reconfigure(int unsigned phase);
      logic [UNIT_W-1:0] lo;
      logic [UNIT_W-1:0] hi;
      logic [DUR_W-1:0]  lim;
      settle();
      case (phase % 6)
         0: begin lo = SYNC_LOW_RESET; hi = SYNC_HIGH_RESET; lim = LIMIT_RESET; end
         1: begin
            lo  = UNIT_W'($urandom_range(0, 1000));
            hi  = UNIT_W'(32'(lo) + $urandom_range(2, 600));
            lim = DUR_W'($urandom_range(1, 3000));
         end
         2: begin lo = '0; hi = '1; lim = '0; end
         3: begin lo = '0; hi = '1; lim = '1; end
         4: begin lo = '1; hi = '0; lim = 16'd1; end
         default: begin
            lo  = UNIT_W'($urandom);
            hi  = UNIT_W'($urandom);
            lim = $urandom_range(0, 1) ? 16'hFFFE : DUR_W'($urandom);
         end
      endcase
      // upper bits carry junk; the block keeps only the register width
      write_reg(REG_SYNC_LOW,  {$urandom} & ~32'h7FF | 32'(lo));
      write_reg(REG_SYNC_HIGH, {$urandom} & ~32'h7FF | 32'(hi));
      write_reg(REG_LIMIT,     {$urandom} & ~32'hFFFF | 32'(lim));
      write_reg(REG_UNUSED,    $urandom);
   endtask

   initial begin
      int unsigned frame_no;
      int unsigned phase;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      reconfigure(0);

      // short frames: field extremes and the limit boundary, all length faults
      frame_pulses = '{16'h0000};
      send_frame();
      frame_pulses = '{16'hFFFF};
      send_frame();
      frame_pulses = '{sync_pulse(1), 16'd700, 16'd700, 16'd701, 16'd699};
      send_frame();
      frame_pulses = '{sync_pulse(0), 16'hFFFF, 16'h0000, 16'h5555, 16'hAAAA, 16'h0001};
      send_frame();

      frame_no = 0;
      phase    = 1;
      while (items_sent < ITEM_TARGET) begin
         if (frame_no != 0 && frame_no % FRAMES_PER_PHASE == 0) begin
            reconfigure(phase);
            phase++;
         end
         build_frame(pick_kind(frame_no));
         send_frame();
         frame_no++;
      end

      settle();
      if (sb.errors == 0 && sb.waiting() == 0)
         $display("ook_pulse_frame_decoder test passed");
      else
         $display("ook_pulse_frame_decoder test failed");
      $finish;
   end

endmodule
